@@ rtl/core/mte_pkg.sv @@
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants of the minimal transversal enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

  localparam int MAX_N    = 20;
  localparam int MAX_ROWS = 16;
  localparam int MAX_OUT  = 64;

  localparam int EC_W     = 5;
  localparam int EC_RESET = 20;
  localparam int MASK_W   = MAX_N + 1;
  localparam int ROW_IW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CW   = $clog2(MAX_ROWS + 1);
  localparam int OUT_CW   = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [MAX_N-1:0] row_mask;
  } in_req_t;

  typedef struct packed {
    logic [MAX_N-1:0] blocker_mask;
    logic             has_blocker;
    logic             last;
    logic             overflow;
  } out_res_t;

  typedef struct packed {
    logic             clr;
    logic             load;
    logic [MAX_N-1:0] data;
  } rows_cmd_t;

  typedef struct packed {
    logic             hit;
    logic             single;
    logic [MAX_N-1:0] inter;
  } unit_res_t;

  typedef struct packed {
    logic     vld;
    out_res_t res;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/core/minimal_transversal_enumerator_core.sv @@
// ----------------------------------------------------------------------------
// minimal_transversal_enumerator_core
// Brute-force minimal transversal search over a small stored set family.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_req_t (action, row_mask)
//   out_     out  out_valid/out_ready  out_res_t (blocker_mask, flags)
//   cfg_     in   cfg_valid/cfg_ready  element_count, 5 bits
//
// clear and load requests act on the row store when accepted. a run tests one
// stored row per cycle in the shared row unit while no found blocker waits on a
// full output register: a mask is tested row by row until a row it misses, and
// a mask that meets every row gets a closing step that checks it is minimal.
// in_ready is low for the whole run. reset clears the row count and sets
// element_count to 20.
// ----------------------------------------------------------------------------
`default_nettype none

module minimal_transversal_enumerator_core
  import mte_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire in_req_t         in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_res_t             out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [EC_W-1:0] cfg_data
);

  logic [EC_W-1:0]   ec_r, ec_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_res_t          out_res_r, out_res_nxt;
  logic              in_acc;
  logic              seq_idle;
  logic              slot_free;
  rows_cmd_t         rows_cmd;
  logic [ROW_IW-1:0] rd_idx;
  logic [MAX_N-1:0]  rd_data;
  logic [ROW_CW-1:0] row_cnt;
  push_t             push;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle;
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_vld_r || out_ready;

  assign rows_cmd.clr  = in_acc && (in_data.action == ACT_CLEAR);
  assign rows_cmd.load = in_acc && (in_data.action == ACT_LOAD);
  assign rows_cmd.data = in_data.row_mask;

  mte_rows u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (rows_cmd),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .count_o   (row_cnt)
  );

  mte_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_acc && (in_data.action == ACT_RUN)),
    .ec_i        (ec_r),
    .row_cnt_i   (row_cnt),
    .row_data_i  (rd_data),
    .slot_free_i (slot_free),
    .rd_idx_o    (rd_idx),
    .idle_o      (seq_idle),
    .push_o      (push)
  );

  always_comb begin
    ec_nxt      = cfg_valid ? cfg_data : ec_r;
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (push.vld) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = push.res;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r      <= EC_W'(EC_RESET);
      out_vld_r <= 1'b0;
    end else begin
      ec_r      <= ec_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_res_r;

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.action == ACT_RUN) |=> !in_ready)
    else $error("run request did not make the block busy");

  a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> slot_free)
    else $error("result pushed into an occupied output register");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_blocker |-> out_data.last && (out_data.blocker_mask == '0))
    else $error("no-blocker result not final or mask nonzero");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.last && out_data.has_blocker)
    else $error("overflow flag on a non-final result");

endmodule

`default_nettype wire

@@ rtl/core/mte_rows.sv @@
// ----------------------------------------------------------------------------
// mte_rows
// Row store and row count, one write and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_rows
  import mte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rows_cmd_t         cmd_i,
  input  wire logic [ROW_IW-1:0] rd_idx_i,
  output logic      [MAX_N-1:0]  rd_data_o,
  output logic      [ROW_CW-1:0] count_o
);

  logic [MAX_N-1:0]  store_r [MAX_ROWS];
  logic [ROW_CW-1:0] count_r;
  logic [ROW_CW-1:0] count_nxt;
  logic              wr_en;

  assign wr_en = cmd_i.load && (count_r < ROW_CW'(MAX_ROWS));

  always_comb begin
    count_nxt = count_r;
    if (cmd_i.clr) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + ROW_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !cmd_i.clr) begin
      store_r[count_r[ROW_IW-1:0]] <= cmd_i.data;
    end
  end

  assign rd_data_o = store_r[rd_idx_i];
  assign count_o   = count_r;

endmodule

`default_nettype wire

@@ rtl/core/mte_unit.sv @@
// ----------------------------------------------------------------------------
// mte_unit
// Shared row test: intersection, empty check and single-bit check.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_unit
  import mte_pkg::*;
(
  input  wire logic [MAX_N-1:0] mask_i,
  input  wire logic [MAX_N-1:0] row_i,
  output unit_res_t             res_o
);

  logic [MAX_N-1:0] inter;

  assign inter        = mask_i & row_i;
  assign res_o.inter  = inter;
  assign res_o.hit    = |inter;
  assign res_o.single = ((inter & (inter - MAX_N'(1))) == '0);

endmodule

`default_nettype wire

@@ rtl/core/mte_seq.sv @@
// ----------------------------------------------------------------------------
// mte_seq
// Sweep sequencer: walks masks and rows, holds one pending blocker.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_seq
  import mte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic [EC_W-1:0]   ec_i,
  input  wire logic [ROW_CW-1:0] row_cnt_i,
  input  wire logic [MAX_N-1:0]  row_data_i,
  input  wire logic              slot_free_i,
  output logic      [ROW_IW-1:0] rd_idx_o,
  output logic                   idle_o,
  output push_t                  push_o
);

  seq_state_t        state_r, state_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [MASK_W-1:0] limit_r, limit_nxt;
  logic [ROW_CW-1:0] idx_r, idx_nxt;
  logic [MAX_N-1:0]  priv_r, priv_nxt;
  logic [MAX_N-1:0]  pend_r, pend_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [OUT_CW-1:0] cnt_r, cnt_nxt;
  logic [EC_W-1:0]   n_eff;
  logic [MASK_W-1:0] mask_inc;
  unit_res_t         ures;

  mte_unit u_unit (
    .mask_i (mask_r[MAX_N-1:0]),
    .row_i  (row_data_i),
    .res_o  (ures)
  );

  assign n_eff    = (ec_i > EC_W'(MAX_N)) ? EC_W'(MAX_N) : ec_i;
  assign mask_inc = mask_r + MASK_W'(1);
  assign rd_idx_o = idx_r[ROW_IW-1:0];
  assign idle_o   = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    mask_nxt     = mask_r;
    limit_nxt    = limit_r;
    idx_nxt      = idx_r;
    priv_nxt     = priv_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    cnt_nxt      = cnt_r;
    push_o       = '0;
    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          mask_nxt     = MASK_W'(1);
          limit_nxt    = MASK_W'(1) << n_eff;
          idx_nxt      = '0;
          priv_nxt     = '0;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = (n_eff == '0) ? S_FIN : S_ROW;
        end
      end
      S_ROW: begin
        if (idx_r == row_cnt_i) begin
          if (priv_r == mask_r[MAX_N-1:0]) begin
            // minimal transversal found
            if (cnt_r == OUT_CW'(MAX_OUT)) begin
              if (slot_free_i) begin
                push_o.vld              = 1'b1;
                push_o.res.blocker_mask = pend_r;
                push_o.res.has_blocker  = 1'b1;
                push_o.res.last         = 1'b1;
                push_o.res.overflow     = 1'b1;
                state_nxt               = S_IDLE;
              end
            end else if (!pend_vld_r || slot_free_i) begin
              if (pend_vld_r) begin
                push_o.vld              = 1'b1;
                push_o.res.blocker_mask = pend_r;
                push_o.res.has_blocker  = 1'b1;
              end
              pend_nxt     = mask_r[MAX_N-1:0];
              pend_vld_nxt = 1'b1;
              cnt_nxt      = cnt_r + OUT_CW'(1);
              mask_nxt     = mask_inc;
              idx_nxt      = '0;
              priv_nxt     = '0;
              if (mask_inc == limit_r) begin
                state_nxt = S_FIN;
              end
            end
          end else begin
            mask_nxt = mask_inc;
            idx_nxt  = '0;
            priv_nxt = '0;
            if (mask_inc == limit_r) begin
              state_nxt = S_FIN;
            end
          end
        end else if (!ures.hit) begin
          mask_nxt = mask_inc;
          idx_nxt  = '0;
          priv_nxt = '0;
          if (mask_inc == limit_r) begin
            state_nxt = S_FIN;
          end
        end else begin
          if (ures.single) begin
            priv_nxt = priv_r | ures.inter;
          end
          idx_nxt = idx_r + ROW_CW'(1);
        end
      end
      S_FIN: begin
        if (slot_free_i) begin
          push_o.vld              = 1'b1;
          push_o.res.blocker_mask = pend_vld_r ? pend_r : '0;
          push_o.res.has_blocker  = pend_vld_r;
          push_o.res.last         = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    limit_r <= limit_nxt;
    idx_r   <= idx_nxt;
    priv_r  <= priv_nxt;
    pend_r  <= pend_nxt;
  end

endmodule

`default_nettype wire
